>>> src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> src/bbrr_pkg.sv
package bbrr_pkg;

   // item kinds
   localparam logic ACT_PIXEL = 1'b0;
   localparam logic ACT_DRAIN = 1'b1;

   // pixel format codes
   localparam logic [1:0] FMT_8  = 2'd0;
   localparam logic [1:0] FMT_16 = 2'd1;

   // register indexes
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_BLUR_RADIUS  = 2'd2;
   localparam logic [1:0] CSR_PIXEL_FORMAT = 2'd3;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_HSUM,
      S_HLAST,
      S_OCHK,
      S_VSUM,
      S_VLAST,
      S_DIV,
      S_EMIT
   } bbrr_state_type;

endpackage

>>> src/bbrr_ram.sv
module bbrr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/bbrr_div.sv
module bbrr_div #(
   parameter int NW = 44,
   parameter int DW = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] numer,
   input  logic [DW-1:0] denom,
   output logic          done,
   output logic [NW-1:0] quot
);

   localparam int CNTW = $clog2(NW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0]   quo_ff, quo_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   den_ff, den_in;
   logic [DW:0]     trial;
   logic            fits;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial   = {rem_ff, quo_ff[NW-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(NW);
         quo_in  = numer;
         rem_in  = '0;
         den_in  = denom;
      end else if (busy_ff) begin
         rem_in = fits ? DW'(trial - {1'b0, den_ff}) : DW'(trial);
         quo_in = {quo_ff[NW-2:0], fits};
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

>>> src/integer_box_blur_reflect_round.sv
// Box blur over one frame of unsigned pixels in raster order, with mirror
// borders that skip the edge pixel and a mean rounded half up and clamped to
// the pixel format maximum. Items are handled one at a time. A pixel item is
// written to the pixel window store, then each horizontal row sum it completes
// (one per pixel, r+1 at the end of a row) is read out term by term through
// the single read port of that store. When an output is ready the vertical
// sum is read through the read port of the row-sum line store, then the
// bit-serial divider and the output register finish the result, which may
// first wait there until the previous result has been taken.
// Results appear in raster order once row y+r is in; drain items release
// the last rows. The stores need no clearing pass after reset.
`include "assert_macros.svh"

module integer_box_blur_reflect_round #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_RADIUS = 15,
   parameter int PIXEL_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [31:0] req_pixel_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_blurred_value,
   output logic        rsp_frame_last,
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   import bbrr_pkg::*;

   localparam int LB   = $clog2(2 * MAX_RADIUS + 2);
   localparam int CB   = $clog2(MAX_WIDTH);
   localparam int WCW  = $clog2(MAX_WIDTH + 1);
   localparam int RW   = $clog2(MAX_RADIUS + 1);
   localparam int JW   = $clog2(2 * MAX_RADIUS + 1);
   localparam int SUMW = PIXEL_BITS + $clog2(2 * MAX_RADIUS + 1);
   localparam int COLW = PIXEL_BITS + 2 * $clog2(2 * MAX_RADIUS + 1);
   localparam int DDW  = 2 * $clog2(2 * MAX_RADIUS + 2);
   localparam int NW   = COLW + 2;
   localparam int AW   = LB + CB;
   localparam int SCW  = CB + 4;
   localparam int SRW  = 19;

   // configuration
   logic [10:0] image_width_ff;
   logic [15:0] image_height_ff;
   logic [3:0]  blur_radius_ff;
   logic [1:0]  pixel_format_ff;

   // control
   bbrr_state_type state_ff, state_in;
   logic [CB-1:0]   in_col_ff, in_col_in;
   logic [15:0]     in_row_ff, in_row_in;
   logic [CB-1:0]   out_col_ff, out_col_in;
   logic [15:0]     out_row_ff, out_row_in;
   logic [JW-1:0]   j_ff, j_in;
   logic [COLW-1:0] acc_ff, acc_in;
   logic [CB-1:0]   x_ff, x_in;
   logic [CB-1:0]   xe_ff, xe_in;
   logic [LB-1:0]   line_ff, line_in;
   logic            rv_ff, rv_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [31:0]     rsp_value_ff, rsp_value_in;
   logic            rsp_last_ff, rsp_last_in;

   // geometry
   logic [WCW-1:0]  w_val;
   logic [15:0]     h_val;
   logic [RW-1:0]   r_val;
   logic [31:0]     min_wh;
   logic [31:0]     r_tmp;
   logic [RW:0]     d_val;
   logic [DDW-1:0]  dd_val;
   logic [31:0]     fmt_max;
   logic [31:0]     lim;
   logic [31:0]     maxv;

   // addressing
   logic signed [SCW-1:0] col_i, col_m, wv_s;
   logic signed [SRW-1:0] row_i, row_m, hv_s;

   // stores and divider
   logic              win_we, win_re;
   logic [LB-1:0]     win_wa;
   logic [PIXEL_BITS-1:0] win_wd, win_rd;
   logic              line_we, line_re;
   logic [AW-1:0]     line_wa, line_ra;
   logic [SUMW-1:0]   line_wd, line_rd;
   logic              div_start, div_done;
   logic [NW-1:0]     div_num, div_quot;
   logic [DDW:0]      div_den;
   logic [COLW-1:0]   col_sum;

   // handshake helpers
   logic pix_ok, out_ok, emit_go, frame_last, last_j;
   logic [31:0] need;

   // clamped frame geometry
   always_comb begin
      if (32'(image_width_ff) < 32'd3) begin
         w_val = WCW'(3);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         w_val = WCW'(MAX_WIDTH);
      end else begin
         w_val = WCW'(image_width_ff);
      end
      h_val  = (image_height_ff < 16'd3) ? 16'd3 : image_height_ff;
      min_wh = (32'(w_val) < 32'(h_val)) ? 32'(w_val) : 32'(h_val);
      r_tmp  = 32'(blur_radius_ff);
      if (r_tmp < 32'd1) begin
         r_tmp = 32'd1;
      end
      if (r_tmp > MAX_RADIUS) begin
         r_tmp = 32'(MAX_RADIUS);
      end
      if (r_tmp > ((min_wh - 32'd1) >> 1)) begin
         r_tmp = (min_wh - 32'd1) >> 1;
      end
      r_val  = RW'(r_tmp);
      d_val  = {r_val, 1'b1};
      dd_val = DDW'(d_val) * DDW'(d_val);
   end

   // format maximum
   always_comb begin
      case (pixel_format_ff)
         FMT_8:   fmt_max = 32'h0000_00FF;
         FMT_16:  fmt_max = 32'h0000_FFFF;
         default: fmt_max = 32'hFFFF_FFFF;
      endcase
      lim  = 32'((64'd1 << PIXEL_BITS) - 64'd1);
      maxv = (fmt_max < lim) ? fmt_max : lim;
   end

   // mirrored column for the window read
   always_comb begin
      wv_s  = $signed(SCW'(w_val));
      col_i = $signed(SCW'(x_ff) + SCW'(j_ff) - SCW'(r_val));
      if (col_i < 0) begin
         col_m = -col_i;
      end else if (col_i >= wv_s) begin
         col_m = wv_s + wv_s - $signed(SCW'(2)) - col_i;
      end else begin
         col_m = col_i;
      end
   end

   // mirrored row for the line read
   always_comb begin
      hv_s  = $signed(SRW'(h_val));
      row_i = $signed(SRW'(out_row_ff) + SRW'(j_ff) - SRW'(r_val));
      if (row_i < 0) begin
         row_m = -row_i;
      end else if (row_i >= hv_s) begin
         row_m = hv_s + hv_s - $signed(SRW'(2)) - row_i;
      end else begin
         row_m = row_i;
      end
   end

   // readiness and end of frame
   always_comb begin
      pix_ok = (req_action == ACT_PIXEL) && (in_row_ff < h_val)
               && (32'(in_col_ff) < 32'(w_val));
      need   = 32'(out_row_ff) + 32'(r_val);
      if (need > 32'(h_val) - 32'd1) begin
         need = 32'(h_val) - 32'd1;
      end
      out_ok     = (32'(in_row_ff) > need) && (32'(out_col_ff) < 32'(w_val));
      frame_last = (32'(out_row_ff) == 32'(h_val) - 32'd1)
                   && (32'(out_col_ff) == 32'(w_val) - 32'd1);
      last_j     = j_ff == JW'({r_val, 1'b0});
   end

   assign win_wa  = LB'(in_col_ff);
   assign win_wd  = PIXEL_BITS'(req_pixel_value & maxv);
   assign line_ra = {LB'(row_m), CB'(out_col_ff)};
   assign line_wa = {line_ff, CB'(x_ff)};
   assign line_wd = SUMW'(acc_ff + COLW'(win_rd));
   assign col_sum = acc_ff + COLW'(line_rd);
   assign div_num = {NW'(col_sum) << 1} + NW'(dd_val);
   assign div_den = {dd_val, 1'b0};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      j_in         = j_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      xe_in        = xe_ff;
      line_in      = line_ff;
      rv_in        = (state_ff == S_HSUM) || (state_ff == S_VSUM);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      req_ready    = 1'b0;
      win_we       = 1'b0;
      win_re       = 1'b0;
      line_we      = 1'b0;
      line_re      = 1'b0;
      div_start    = 1'b0;
      emit_go      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = S_OCHK;
               if (pix_ok) begin
                  win_we  = 1'b1;
                  line_in = LB'(in_row_ff);
                  j_in    = '0;
                  acc_in  = '0;
                  x_in    = CB'(in_col_ff - CB'(r_val));
                  if (32'(in_col_ff) == 32'(w_val) - 32'd1) begin
                     xe_in     = CB'(w_val - WCW'(1));
                     in_col_in = '0;
                     in_row_in = in_row_ff + 16'd1;
                  end else begin
                     xe_in     = CB'(in_col_ff - CB'(r_val));
                     in_col_in = in_col_ff + CB'(1);
                  end
                  if (32'(in_col_ff) >= 32'(r_val)) begin
                     state_in = S_HSUM;
                  end
               end
            end
         end
         S_HSUM: begin
            win_re = 1'b1;
            if (rv_ff) begin
               acc_in = acc_ff + COLW'(win_rd);
            end
            if (last_j) begin
               state_in = S_HLAST;
            end else begin
               j_in = j_ff + JW'(1);
            end
         end
         S_HLAST: begin
            line_we = 1'b1;
            j_in    = '0;
            acc_in  = '0;
            if (x_ff == xe_ff) begin
               state_in = S_OCHK;
            end else begin
               x_in     = x_ff + CB'(1);
               state_in = S_HSUM;
            end
         end
         S_OCHK: begin
            j_in     = '0;
            acc_in   = '0;
            state_in = out_ok ? S_VSUM : S_IDLE;
         end
         S_VSUM: begin
            line_re = 1'b1;
            if (rv_ff) begin
               acc_in = acc_ff + COLW'(line_rd);
            end
            if (last_j) begin
               state_in = S_VLAST;
            end else begin
               j_in = j_ff + JW'(1);
            end
         end
         S_VLAST: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               emit_go      = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_value_in = (div_quot > NW'(maxv)) ? maxv : 32'(div_quot);
               rsp_last_in  = frame_last;
               state_in     = S_IDLE;
               if (frame_last) begin
                  in_col_in  = '0;
                  in_row_in  = '0;
                  out_col_in = '0;
                  out_row_in = '0;
               end else if (32'(out_col_ff) == 32'(w_val) - 32'd1) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + 16'd1;
               end else begin
                  out_col_in = out_col_ff + CB'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      // a register write abandons the frame
      if (csr_wen) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= 11'd1024;
         image_height_ff <= 16'd480;
         blur_radius_ff  <= 4'd1;
         pixel_format_ff <= FMT_8;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[10:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
            CSR_BLUR_RADIUS:  blur_radius_ff  <= csr_wdata[3:0];
            CSR_PIXEL_FORMAT: pixel_format_ff <= csr_wdata[1:0];
            default:          image_width_ff  <= image_width_ff;
         endcase
      end
   end

   // control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         rv_ff        <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      j_ff         <= j_in;
      acc_ff       <= acc_in;
      x_ff         <= x_in;
      xe_ff        <= xe_in;
      line_ff      <= line_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // last pixels of the current row
   bbrr_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (1 << LB)
   ) u_window (
      .clock   (clock),
      .wr_en   (win_we),
      .wr_addr (win_wa),
      .wr_data (win_wd),
      .rd_en   (win_re),
      .rd_addr (LB'(col_m)),
      .rd_data (win_rd)
   );

   // horizontal sums of recent rows
   bbrr_ram #(
      .WIDTH (SUMW),
      .DEPTH (1 << AW)
   ) u_lines (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (line_wa),
      .wr_data (line_wd),
      .rd_en   (line_re),
      .rd_addr (line_ra),
      .rd_data (line_rd)
   );

   // rounded mean
   bbrr_div #(
      .NW (NW),
      .DW (DDW + 1)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_blurred_value = rsp_value_ff;
   assign rsp_frame_last    = rsp_last_ff;

   `ASSERT_CLK(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT), "result raised outside emit")
   `ASSERT_NEVER(a_div_done_state, clock, reset, div_done && (state_ff != S_DIV), "divider finished while not waited on")
   `ASSERT_CLK(a_last_clears, clock, reset, (emit_go && frame_last) |=> (in_row_ff == '0 && out_row_ff == '0 && out_col_ff == '0), "frame end did not clear position")

endmodule
